// File: src/tswu_pkg.sv
// ----------------------------------------------------------------------------
// tswu_pkg: shared types and constants for the typed stack
// entry layout, operation codes, status codes and derived widths
// ----------------------------------------------------------------------------
package tswu_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int TYPE_BITS   = 8;
  localparam int VALUE_BITS  = 32;

  // occupancy and count hold 0..STACK_DEPTH, cell index holds 0..STACK_DEPTH-1
  localparam int OCC_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int OP_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_DROP   = 3'd2,
    OP_PEEK   = 3'd3,
    OP_UNWIND = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_OVER  = 2'd1,
    STAT_UNDER = 2'd2
  } status_e;

  typedef struct packed {
    logic [TYPE_BITS-1:0]  etype;
    logic [VALUE_BITS-1:0] evalue;
  } entry_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_cmd_t;

endpackage

// File: src/tswu_cell.sv
// ----------------------------------------------------------------------------
// tswu_cell: one stack slot
// takes its upper neighbor on push, its lower neighbor on pop
// ----------------------------------------------------------------------------
module tswu_cell (
  input  logic                clk_i,
  input  tswu_pkg::shift_cmd_t cmd_i,
  input  tswu_pkg::entry_t    above_i,
  input  tswu_pkg::entry_t    below_i,
  output tswu_pkg::entry_t    entry_o
);
  import tswu_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      entry_q <= above_i;
    end else if (cmd_i.pop) begin
      entry_q <= below_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// File: src/tswu_chain.sv
// ----------------------------------------------------------------------------
// tswu_chain: row of stack cells, cell 0 is the top of stack
// also selects the entry at a given depth for peek
// ----------------------------------------------------------------------------
module tswu_chain (
  input  logic                        clk_i,
  input  tswu_pkg::shift_cmd_t        cmd_i,
  input  tswu_pkg::entry_t            push_entry_i,
  input  logic [tswu_pkg::IDX_W-1:0]  peek_idx_i,
  output tswu_pkg::entry_t            top_o,
  output tswu_pkg::entry_t            peek_o
);
  import tswu_pkg::*;

  entry_t cell_q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t above;
    entry_t below;

    if (i == 0) begin : g_first
      assign above = push_entry_i;
    end else begin : g_mid_up
      assign above = cell_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_mid_dn
      assign below = cell_q[i+1];
    end

    tswu_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd_i),
      .above_i (above),
      .below_i (below),
      .entry_o (cell_q[i])
    );
  end

  assign top_o  = cell_q[0];
  assign peek_o = cell_q[peek_idx_i];

endmodule

// File: src/typed_stack_with_unwind.sv
// ----------------------------------------------------------------------------
// typed_stack_with_unwind: bounded lifo of typed entries with unwind
// push, pop, drop n, peek at depth and unwind to a type
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o carry one operation per item
//   (op, elem_type, elem_value, count). output channel: out_valid_o /
//   out_stall_i carry result items; last_o marks the final result of an item.
//   push, pop, peek, unknown ops and errors give one result, registered, in the
//   cycle after acceptance; the next item can be taken in the same cycle the
//   result is taken, so these run at one item per cycle.
//   drop n answers at once (occupancy already reduced), then shifts the cell
//   row up one place per cycle until it has moved n places, while input is
//   stalled.
//   unwind pops one entry per cycle while its result register is free, one
//   result each (an empty stack gives a single result with no entry).
//   every step shifts the whole cell row by one place, which sets these rates.
//   reset empties the stack; cell contents are left as they were.
//   a stall on the output holds the result register; input stays stalled and
//   an unwind in progress waits until its result register frees up.
// ----------------------------------------------------------------------------
module typed_stack_with_unwind (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tswu_pkg::OP_W-1:0]           op_i,
  input  logic [tswu_pkg::TYPE_BITS-1:0]      elem_type_i,
  input  logic [tswu_pkg::VALUE_BITS-1:0]     elem_value_i,
  input  logic [tswu_pkg::OCC_W-1:0]          count_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                has_element_o,
  output logic [tswu_pkg::TYPE_BITS-1:0]      out_type_o,
  output logic [tswu_pkg::VALUE_BITS-1:0]     out_value_o,
  output logic [tswu_pkg::OCC_W-1:0]          occupancy_o,
  output logic [1:0]                          status_o,
  output logic                                last_o
);
  import tswu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DROP,
    S_UNWIND
  } state_e;

  localparam logic [OCC_W-1:0] FULL = OCC_W'(STACK_DEPTH);
  localparam logic [OCC_W-1:0] ONE  = OCC_W'(1);

  state_e                 state_q, state_d;
  logic [OCC_W-1:0]       occ_q, occ_d;        // entries held
  logic [OCC_W-1:0]       remain_q, remain_d;  // shifts left for drop
  logic [TYPE_BITS-1:0]   utype_q, utype_d;    // type unwind searches for

  // result register
  logic                   out_valid_q, out_valid_d;
  logic                   has_q, has_d;
  logic [TYPE_BITS-1:0]   otype_q, otype_d;
  logic [VALUE_BITS-1:0]  ovalue_q, ovalue_d;
  logic [OCC_W-1:0]       oocc_q, oocc_d;
  status_e                status_q, status_d;
  logic                   last_q, last_d;

  shift_cmd_t             cmd;
  entry_t                 push_entry;
  entry_t                 top_entry;
  entry_t                 peek_entry;
  logic                   out_free;
  logic                   in_accept;
  logic                   hit;

  assign push_entry = '{etype: elem_type_i, evalue: elem_value_i};

  tswu_chain u_chain (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .push_entry_i (push_entry),
    .peek_idx_i   (count_i[IDX_W-1:0]),
    .top_o        (top_entry),
    .peek_o       (peek_entry)
  );

  // result register can load when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign hit        = (top_entry.etype == utype_q);

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    remain_d    = remain_q;
    utype_d     = utype_q;
    cmd         = '0;
    out_valid_d = out_valid_q && out_stall_i;
    has_d       = has_q;
    otype_d     = otype_q;
    ovalue_d    = ovalue_q;
    oocc_d      = oocc_q;
    status_d    = status_q;
    last_d      = last_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          // default result: no entry, ok, final
          out_valid_d = 1'b1;
          has_d       = 1'b0;
          otype_d     = '0;
          ovalue_d    = '0;
          status_d    = STAT_OK;
          last_d      = 1'b1;
          case (op_e'(op_i))
            OP_PUSH: begin
              if (occ_q == FULL) begin
                status_d = STAT_OVER;
              end else begin
                cmd.push = 1'b1;
                occ_d    = occ_q + ONE;
              end
            end
            OP_POP: begin
              if (occ_q == '0) begin
                status_d = STAT_UNDER;
              end else begin
                cmd.pop  = 1'b1;
                occ_d    = occ_q - ONE;
                has_d    = 1'b1;
                otype_d  = top_entry.etype;
                ovalue_d = top_entry.evalue;
              end
            end
            OP_DROP: begin
              if (count_i > occ_q) begin
                status_d = STAT_UNDER;
              end else if (count_i != '0) begin
                // answer now, shift the cells up in the background
                occ_d    = occ_q - count_i;
                remain_d = count_i;
                state_d  = S_DROP;
              end
            end
            OP_PEEK: begin
              if (count_i >= occ_q) begin
                status_d = STAT_UNDER;
              end else begin
                has_d    = 1'b1;
                otype_d  = peek_entry.etype;
                ovalue_d = peek_entry.evalue;
              end
            end
            OP_UNWIND: begin
              if (occ_q != '0) begin
                // results come from the unwind loop
                out_valid_d = 1'b0;
                utype_d     = elem_type_i;
                state_d     = S_UNWIND;
              end
            end
            default: ;  // unknown op: ok, nothing changes
          endcase
          oocc_d = occ_d;
        end
      end

      S_DROP: begin
        cmd.pop  = 1'b1;
        remain_d = remain_q - ONE;
        if (remain_q == ONE) begin
          state_d = S_IDLE;
        end
      end

      S_UNWIND: begin
        if (out_free) begin
          cmd.pop     = 1'b1;
          occ_d       = occ_q - ONE;
          out_valid_d = 1'b1;
          has_d       = 1'b1;
          otype_d     = top_entry.etype;
          ovalue_d    = top_entry.evalue;
          oocc_d      = occ_q - ONE;
          status_d    = STAT_OK;
          last_d      = hit || (occ_q == ONE);
          if (hit || (occ_q == ONE)) begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      remain_q    <= '0;
      utype_q     <= '0;
      out_valid_q <= 1'b0;
      has_q       <= 1'b0;
      otype_q     <= '0;
      ovalue_q    <= '0;
      oocc_q      <= '0;
      status_q    <= STAT_OK;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      remain_q    <= remain_d;
      utype_q     <= utype_d;
      out_valid_q <= out_valid_d;
      has_q       <= has_d;
      otype_q     <= otype_d;
      ovalue_q    <= ovalue_d;
      oocc_q      <= oocc_d;
      status_q    <= status_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign has_element_o = has_q;
  assign out_type_o    = otype_q;
  assign out_value_o   = ovalue_q;
  assign occupancy_o   = oocc_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

  // occupancy stays within the cell row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FULL)
    else $error("occupancy beyond stack depth");

  // a result without an entry carries zero type and value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_element_o |-> out_type_o == '0 && out_value_o == '0)
    else $error("empty result carries data");

  // an error result is always final and carries no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> last_o && !has_element_o)
    else $error("error result malformed");

  // an accepted push on a non-full stack grows occupancy by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (op_i == OP_PUSH) && (occ_q != FULL) |=> occ_q == $past(occ_q) + ONE)
    else $error("push did not grow stack");

endmodule

// File: tb/tb_typed_stack_with_unwind.sv
// ----------------------------------------------------------------------------
// tb_typed_stack_with_unwind: self-checking testbench for the typed stack
// drives push, pop, drop, peek, unwind and reserved ops through the
// valid/stall input channel, predicts every result item with a shadow stack
// and checks each accepted result item field by field, in order
// ----------------------------------------------------------------------------
module tb_typed_stack_with_unwind;
  timeunit 1ns;
  timeprecision 1ps;

  import tswu_pkg::*;

  // cycles without any accepted item before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  // receiver hold-off used to fill the block up
  localparam int LONG_HOLD      = 300;

  // one result item as the block presents it
  typedef struct packed {
    logic                  has_element;
    logic [TYPE_BITS-1:0]  etype;
    logic [VALUE_BITS-1:0] evalue;
    logic [OCC_W-1:0]      occupancy;
    logic [1:0]            status;
    logic                  last;
  } result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       op;
  logic [TYPE_BITS-1:0]  elem_type;
  logic [VALUE_BITS-1:0] elem_value;
  logic [OCC_W-1:0]      count;
  logic                  out_valid;
  logic                  out_stall;
  logic                  has_element;
  logic [TYPE_BITS-1:0]  out_type;
  logic [VALUE_BITS-1:0] out_value;
  logic [OCC_W-1:0]      occupancy;
  logic [1:0]            status;
  logic                  res_last;

  // shadow copy of the stack contents, advanced on every accepted item
  logic [TYPE_BITS-1:0]  shadow_type  [STACK_DEPTH];
  logic [VALUE_BITS-1:0] shadow_value [STACK_DEPTH];
  int                    shadow_fill = 0;

  // results still owed by the block, oldest first
  result_t expected_results[$];

  int err_count   = 0;
  int idle_cycles = 0;

  // sender shaping: burst length left and the largest gap between bursts
  int burst_left = 0;
  int tx_max_gap = 0;

  // receiver shaping: stall pattern select and a long hold-off counter
  int rx_mode   = 0;
  int hold_left = 0;

  typed_stack_with_unwind i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (op),
    .elem_type_i   (elem_type),
    .elem_value_i  (elem_value),
    .count_i       (count),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .has_element_o (has_element),
    .out_type_o    (out_type),
    .out_value_o   (out_value),
    .occupancy_o   (occupancy),
    .status_o      (status),
    .last_o        (res_last)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // one result item as text
  function automatic string fmt_result(result_t r);
    return $sformatf("has=%0b type=%02h value=%08h occ=%0d status=%0d last=%0b",
                     r.has_element, r.etype, r.evalue, r.occupancy, r.status, r.last);
  endfunction

  // ---------------------------------------------------------------------------
  // shadow stack: applies one operation and queues the result items it owes
  // ---------------------------------------------------------------------------
  function automatic void apply_stack_op(logic [OP_W-1:0] cmd, logic [TYPE_BITS-1:0] ty,
                                         logic [VALUE_BITS-1:0] val,
                                         logic [OCC_W-1:0] cnt);
    result_t r;
    int      idx;
    bit      hit;
    r        = '0;
    r.status = STAT_OK;
    r.last   = 1'b1;
    case (cmd)
      OP_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          r.status = STAT_OVER;
        end else begin
          shadow_type[shadow_fill]  = ty;
          shadow_value[shadow_fill] = val;
          shadow_fill++;
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          r.status = STAT_UNDER;
        end else begin
          shadow_fill--;
          r.has_element = 1'b1;
          r.etype       = shadow_type[shadow_fill];
          r.evalue      = shadow_value[shadow_fill];
        end
      end
      OP_DROP: begin
        // dropping zero is fine, dropping more than held changes nothing
        if (int'(cnt) > shadow_fill) r.status = STAT_UNDER;
        else shadow_fill -= int'(cnt);
      end
      OP_PEEK: begin
        // depth 0 is the top, a depth not below the fill is out of range
        if (int'(cnt) >= shadow_fill) begin
          r.status = STAT_UNDER;
        end else begin
          idx           = shadow_fill - 1 - int'(cnt);
          r.has_element = 1'b1;
          r.etype       = shadow_type[idx];
          r.evalue      = shadow_value[idx];
        end
      end
      OP_UNWIND: begin
        // empty stack answers once with no entry, otherwise one item per pop
        if (shadow_fill > 0) begin
          do begin
            idx           = shadow_fill - 1;
            hit           = (shadow_type[idx] == ty);
            shadow_fill   = idx;
            r.has_element = 1'b1;
            r.etype       = shadow_type[idx];
            r.evalue      = shadow_value[idx];
            r.occupancy   = OCC_W'(shadow_fill);
            r.last        = hit || (shadow_fill == 0);
            expected_results.push_back(r);
          end while (!hit && shadow_fill > 0);
          return;
        end
      end
      default: begin
        // reserved op codes are ignored but still answered
      end
    endcase
    r.occupancy = OCC_W'(shadow_fill);
    expected_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one item per call, bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [OP_W-1:0] cmd, logic [TYPE_BITS-1:0] ty,
                           logic [VALUE_BITS-1:0] val, logic [OCC_W-1:0] cnt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    op         <= cmd;
    elem_type  <= ty;
    elem_value <= val;
    count      <= cnt;
    // the item is taken at the first rising edge without input stall
    do @(posedge clk); while (in_stall);
    apply_stack_op(cmd, ty, val, cnt);
  endtask

  // sender pause: valid drops and stays low until nothing is owed
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern per mode, or a long hold-off when requested
  // ---------------------------------------------------------------------------
  initial begin : rx_stall_gen
    int cyc;
    cyc = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ((cyc % 7) < 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: sample at the rising edge, compare once the edge settles
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    result_t got;
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = '{has_element, out_type, out_value, occupancy, status, res_last};
        // expectations from an item taken at this same edge are queued by now
        @(negedge clk);
        if (expected_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: expected none, actual %s",
                   $realtime, fmt_result(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            err_count++;
            $display("%0t: result mismatch: expected %s, actual %s",
                     $realtime, fmt_result(want), fmt_result(got));
          end
        end
      end
    end
  end

  // watchdog: any accepted item on either channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("** typed_stack_with_unwind: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // corner cases from an empty stack: errors, reserved ops, field extremes,
  // unwind with and without a matching type
  task automatic test_directed();
    rx_mode    = 1;
    tx_max_gap = 2;
    send_item(OP_POP, '0, '0, '0);                  // pop of empty stack
    send_item(OP_PEEK, '0, '0, '0);                 // peek on empty stack
    send_item(OP_DROP, '0, '0, '0);                 // dropping zero is ok
    send_item(OP_DROP, '0, '0, OCC_W'(1));          // drop more than held
    send_item(OP_UNWIND, '0, '0, '0);               // unwind of empty stack
    for (int c = OP_UNWIND + 1; c < 2 ** OP_W; c++) begin
      send_item(OP_W'(c), '1, '1, '1 >> 1);         // reserved op codes
    end
    send_item(OP_PUSH, '0, '0, '0);
    send_item(OP_PUSH, '1, '1, '0);
    send_item(OP_PUSH, 8'h5a, 32'ha5a5_a5a5, '0);
    send_item(OP_PUSH, 8'h12, $urandom(), '0);
    send_item(OP_PEEK, '0, '0, '0);                 // top
    send_item(OP_PEEK, '0, '0, OCC_W'(3));          // bottom
    send_item(OP_PEEK, '0, '0, OCC_W'(4));          // one past the bottom
    send_item(OP_DROP, '0, '0, OCC_W'(5));
    send_item(OP_UNWIND, '1, '0, '0);               // stops on the matching entry
    send_item(OP_UNWIND, 8'h77, '0, '0);            // no match, empties the stack
    send_item(OP_PUSH, 8'h80, $urandom(), '0);
    send_item(OP_PUSH, 8'h01, $urandom(), '0);
    send_item(OP_PUSH, 8'h7f, $urandom(), '0);
    send_item(OP_DROP, '0, '0, OCC_W'(2));
    send_item(OP_POP, '0, '0, '0);
    send_item(OP_POP, '0, '0, '0);
  endtask

  // receiver holds off while pushes keep coming: the block backs up, the
  // stack fills and the last pushes overflow
  task automatic test_backpressure();
    rx_mode    = 0;
    tx_max_gap = 0;
    if (shadow_fill > 0) send_item(OP_DROP, '0, '0, OCC_W'(shadow_fill));
    hold_left = LONG_HOLD;
    for (int i = 0; i < STACK_DEPTH + 2; i++) begin
      send_item(OP_PUSH, TYPE_BITS'($urandom_range(0, 3)), $urandom(), '0);
    end
    wait_drained();
  endtask

  // full stack extremes: deepest peek, maximum drop, full-depth unwind
  task automatic test_full_stack();
    rx_mode    = 3;
    tx_max_gap = 0;
    send_item(OP_PEEK, '0, '0, OCC_W'(STACK_DEPTH - 1));
    send_item(OP_PEEK, '0, '0, OCC_W'(STACK_DEPTH));
    send_item(OP_POP, '0, '0, '0);
    send_item(OP_PUSH, 8'hc3, $urandom(), '0);
    send_item(OP_DROP, '0, '0, OCC_W'(STACK_DEPTH));
    send_item(OP_POP, '0, '0, '0);
    for (int i = 0; i < STACK_DEPTH; i++) begin
      send_item(OP_PUSH, TYPE_BITS'(i), $urandom(), '0);
    end
    send_item(OP_UNWIND, '1, '0, '0);               // no match over a full stack
    // match on the bottom entry: last flags both the hit and the empty stack
    send_item(OP_PUSH, 8'h44, $urandom(), '0);
    send_item(OP_PUSH, 8'h45, $urandom(), '0);
    send_item(OP_PUSH, 8'h46, $urandom(), '0);
    send_item(OP_UNWIND, 8'h44, '0, '0);
  endtask

  // random operation mix, mostly well formed: pushes from a small type pool
  // so that unwinds hit, peeks and drops within range, some noise
  task automatic test_random(int n_items);
    logic [TYPE_BITS-1:0]  type_pool [4];
    logic [OP_W-1:0]       cmd;
    logic [TYPE_BITS-1:0]  ty;
    logic [VALUE_BITS-1:0] val;
    logic [OCC_W-1:0]      cnt;
    int                    pick;
    foreach (type_pool[k]) type_pool[k] = TYPE_BITS'($urandom());
    for (int ph = 0; ph < 4; ph++) begin
      rx_mode = ph;
      case (ph)
        0:       tx_max_gap = 0;
        1:       tx_max_gap = 3;
        2:       tx_max_gap = 8;
        default: tx_max_gap = 2;
      endcase
      for (int i = 0; i < n_items / 4; i++) begin
        pick = $urandom_range(0, 99);
        ty   = ($urandom_range(0, 3) == 0) ? TYPE_BITS'($urandom())
                                           : type_pool[$urandom_range(0, 3)];
        val  = $urandom();
        cnt  = OCC_W'($urandom_range(0, STACK_DEPTH));
        if (pick < 38) begin
          cmd = OP_PUSH;
        end else if (pick < 52) begin
          cmd = OP_POP;
        end else if (pick < 62) begin
          cmd = OP_DROP;
          // mostly small valid drops, the rest anywhere in range
          if (shadow_fill > 0 && $urandom_range(0, 4) != 0) begin
            cnt = OCC_W'($urandom_range(0, (shadow_fill < 4) ? shadow_fill : 4));
          end
        end else if (pick < 80) begin
          cmd = OP_PEEK;
          if (shadow_fill > 0 && $urandom_range(0, 5) != 0) begin
            cnt = OCC_W'($urandom_range(0, shadow_fill - 1));
          end
        end else if (pick < 94) begin
          cmd = OP_UNWIND;
          // search for a type that is on the stack most of the time
          if (shadow_fill > 0 && $urandom_range(0, 4) != 0) begin
            ty = shadow_type[$urandom_range(0, shadow_fill - 1)];
          end
        end else begin
          cmd = OP_W'($urandom_range(OP_UNWIND + 1, 2 ** OP_W - 1));
        end
        send_item(cmd, ty, val, cnt);
      end
      if (ph == 1) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst_n = 1'b0;
    in_valid   <= 1'b0;
    op         <= '0;
    elem_type  <= '0;
    elem_value <= '0;
    count      <= '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_full_stack();
    test_random(208);

    // let the last drop finish its shifting and catch any stray result
    wait_drained();
    repeat (STACK_DEPTH + 8) @(posedge clk);

    if (err_count == 0 && expected_results.size() == 0) begin
      $display("** typed_stack_with_unwind: PASSED **");
    end else begin
      $display("** typed_stack_with_unwind: FAILED **");
    end
    $finish;
  end

endmodule
